>>> src/gamepad_report_to_midi_events_macros.svh
// assertion macros for the rtl files
`ifndef GAMEPAD_REPORT_TO_MIDI_EVENTS_MACROS_SVH
`define GAMEPAD_REPORT_TO_MIDI_EVENTS_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GPMIDI_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gpmidi assertion failed");
// next-cycle implication
`define GPMIDI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gpmidi assertion failed");
`else
`define GPMIDI_ASSERT_IMPLY(label, ante, cons)
`define GPMIDI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> src/gpmidi_pkg.sv
`default_nettype none
package gpmidi_pkg;

  localparam int AXIS_COUNT = 6;
  localparam int STEP_COUNT = 22;
  localparam int STEP_W     = $clog2(STEP_COUNT);

  localparam logic [7:0] STATUS_CC       = 8'hB0;
  localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;

  localparam logic [6:0] FACE_NOTE_BASE     = 7'd50;
  localparam logic [6:0] SHOULDER_NOTE_BASE = 7'd62;
  localparam logic [6:0] NOTE_VELOCITY      = 7'd100;

  localparam int FACE_STEP0     = AXIS_COUNT;
  localparam int SHOULDER_STEP0 = AXIS_COUNT + 8;

  typedef enum logic [1:0] {
    SRC_AXIS,
    SRC_FACE,
    SRC_SHOULDER
  } src_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // one microcode word
  typedef struct packed {
    src_t       src;
    logic [2:0] sel;
    logic [6:0] number;
    logic       done;
  } uword_t;

  // hat direction to arrow mask, up=1 right=2 down=4 left=8
  function automatic logic [3:0] hat_arrows(input logic [3:0] hat);
    logic [3:0] m;
    case (hat)
      4'd0:    m = 4'd1;
      4'd1:    m = 4'd3;
      4'd2:    m = 4'd2;
      4'd3:    m = 4'd6;
      4'd4:    m = 4'd4;
      4'd5:    m = 4'd12;
      4'd6:    m = 4'd8;
      4'd7:    m = 4'd9;
      default: m = 4'd0;
    endcase
    return m;
  endfunction

  // microcode rom: axis steps, then face bits, then shoulder bits
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t     w;
    logic [2:0] i;
    w.done = (step == STEP_W'(STEP_COUNT - 1));
    if (step < STEP_W'(FACE_STEP0)) begin
      i        = step[2:0];
      w.src    = SRC_AXIS;
      w.sel    = i;
      w.number = {4'd0, i} + 7'd1;
    end else if (step < STEP_W'(SHOULDER_STEP0)) begin
      i        = 3'(step - STEP_W'(FACE_STEP0));
      w.src    = SRC_FACE;
      w.sel    = i;
      w.number = FACE_NOTE_BASE + {3'd0, i, 1'b0} + 7'd2;
    end else begin
      i        = 3'(step - STEP_W'(SHOULDER_STEP0));
      w.src    = SRC_SHOULDER;
      w.sel    = i;
      w.number = SHOULDER_NOTE_BASE + {3'd0, i, 1'b0} + 7'd2;
    end
    return w;
  endfunction

endpackage
`default_nettype wire

>>> src/gamepad_report_to_midi_events.sv
// an accepted request puts the sequencer in its run state at step zero; the event of each
//   pending step is written to the output register when that step is reached and the output is free
// throughput: a 22-step microcode sequencer walks each report, one step per cycle;
//   steps with an event wait while the output register is full and stalled
// a new report is taken only once the walk of the previous one has finished and the sequencer is idle
// reset clears the primed flag, the sequencer and the output valid
`default_nettype none
`include "gamepad_report_to_midi_events_macros.svh"

module gamepad_report_to_midi_events
  import gpmidi_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_left_x,
  input  wire logic [7:0] in_left_y,
  input  wire logic [7:0] in_right_x,
  input  wire logic [7:0] in_right_y,
  input  wire logic [7:0] in_left_trigger,
  input  wire logic [7:0] in_right_trigger,
  input  wire logic [7:0] in_face_and_hat,
  input  wire logic [7:0] in_shoulder_buttons,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_status_byte,
  output logic [6:0]      out_number,
  output logic [6:0]      out_amount,
  output logic            out_last
);

  // sequencer control
  state_t                  state_r, state_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [STEP_COUNT-1:0]   mask_r, mask_nxt;   // one pending-event bit per step

  // report history; after a request these also hold the report being walked
  logic                    primed_r;
  logic [6:0]              prev_axes_r [AXIS_COUNT];
  logic [7:0]              prev_face_r;
  logic [7:0]              prev_shoulder_r;

  // output register
  logic                    out_valid_r;
  logic [7:0]              out_status_r;
  logic [6:0]              out_number_r;
  logic [6:0]              out_amount_r;
  logic                    out_last_r;

  logic                    in_accept;
  logic [6:0]              half_in [AXIS_COUNT];
  logic [7:0]              face_in;
  logic [AXIS_COUNT-1:0]   axis_chg;
  logic [7:0]              face_chg;
  logic [7:0]              shoulder_chg;

  uword_t                  uw;
  logic                    cur_pending;
  logic                    slot_free;
  logic                    emit;
  logic                    advance;
  logic [STEP_COUNT-1:0]   mask_left;
  logic [7:0]              ev_status;
  logic [6:0]              ev_amount;
  logic                    ev_bit;
  logic                    status_ok;

  // halve the axes, map the hat nibble
  assign half_in[0] = in_left_x[7:1];
  assign half_in[1] = in_left_y[7:1];
  assign half_in[2] = in_right_x[7:1];
  assign half_in[3] = in_right_y[7:1];
  assign half_in[4] = in_left_trigger[7:1];
  assign half_in[5] = in_right_trigger[7:1];
  assign face_in    = {in_face_and_hat[7:4], hat_arrows(in_face_and_hat[3:0])};

  // change detect against history; first report sends every axis and no notes
  always_comb begin
    for (int i = 0; i < AXIS_COUNT; i++) begin
      axis_chg[i] = !primed_r || (half_in[i] != prev_axes_r[i]);
    end
    face_chg     = primed_r ? (face_in ^ prev_face_r) : 8'd0;
    shoulder_chg = primed_r ? (in_shoulder_buttons ^ prev_shoulder_r) : 8'd0;
  end

  // current microcode word and step handshake
  assign uw          = ucode(step_r);
  assign cur_pending = mask_r[step_r];
  assign slot_free   = !out_valid_r || !out_stall;
  assign mask_left   = mask_r & ~(STEP_COUNT'(1) << step_r);

  // outputs of the control fsm
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    in_accept = in_valid && (state_r == ST_IDLE);
    emit      = (state_r == ST_RUN) && cur_pending && slot_free;
    advance   = (state_r == ST_RUN) && (!cur_pending || slot_free);
  end

  // next state of the control fsm
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (advance && uw.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // step counter and pending mask; last step jumps back to the start
  always_comb begin
    step_nxt = step_r;
    mask_nxt = mask_r;
    if (in_accept) begin
      step_nxt = '0;
      mask_nxt = {shoulder_chg, face_chg, axis_chg};
    end else if (advance) begin
      mask_nxt = mask_left;
      step_nxt = uw.done ? '0 : step_r + STEP_W'(1);
    end
  end

  // event decode from the microcode word
  always_comb begin
    ev_bit    = 1'b0;
    ev_status = STATUS_CC;
    ev_amount = NOTE_VELOCITY;
    unique case (uw.src)
      SRC_AXIS: begin
        ev_status = STATUS_CC;
        ev_amount = prev_axes_r[uw.sel];
      end
      SRC_FACE: begin
        ev_bit    = prev_face_r[uw.sel];
        ev_status = ev_bit ? STATUS_NOTE_ON : STATUS_NOTE_OFF;
      end
      SRC_SHOULDER: begin
        ev_bit    = prev_shoulder_r[uw.sel];
        ev_status = ev_bit ? STATUS_NOTE_ON : STATUS_NOTE_OFF;
      end
      default: begin
        ev_status = STATUS_CC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      mask_r      <= '0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      mask_r  <= mask_nxt;
      if (in_accept) begin
        primed_r <= 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // history takes the new report at once; the walk reads it from here
  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        prev_axes_r[i] <= half_in[i];
      end
      prev_face_r     <= face_in;
      prev_shoulder_r <= in_shoulder_buttons;
    end
  end

  // output payload, last when no event is pending after this one
  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= ev_status;
      out_number_r <= uw.number;
      out_amount_r <= ev_amount;
      out_last_r   <= (mask_left == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status_byte = out_status_r;
  assign out_number      = out_number_r;
  assign out_amount      = out_amount_r;
  assign out_last        = out_last_r;

  assign status_ok = (out_status_r == STATUS_CC) || (out_status_r == STATUS_NOTE_ON) ||
                     (out_status_r == STATUS_NOTE_OFF);

  // a request starts the walk at step zero
  `GPMIDI_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_r == ST_RUN && step_r == '0)
  // nothing left pending once the sequencer is idle
  `GPMIDI_ASSERT_IMPLY(a_idle_no_pending, state_r == ST_IDLE, mask_r == '0)
  // an event marked last leaves no pending work behind
  `GPMIDI_ASSERT_NEXT(a_last_drains, emit && (mask_left == '0), mask_r == '0)
  // only the three status codes ever leave the block
  `GPMIDI_ASSERT_IMPLY(a_status_legal, out_valid_r, status_ok)

endmodule
`default_nettype wire
